>>> rtl/core/btmx_pkg.sv
// ---------------------------------------------------------------------------
// btmx_pkg: shared types and constants for the binary trie max-XOR unit
// Key and node table sizes, request and response records, status codes.
// ---------------------------------------------------------------------------
package btmx_pkg;

  localparam int KEY_BITS      = 32;
  localparam int NODE_CAPACITY = 4096;
  localparam int IDX_W         = $clog2(NODE_CAPACITY);
  localparam int NU_W          = $clog2(NODE_CAPACITY + 1);
  localparam int LVL_W         = $clog2(KEY_BITS);
  localparam int REQ_DEPTH     = 2;
  localparam int REQ_PTR_W     = $clog2(REQ_DEPTH);
  localparam int REQ_CNT_W     = $clog2(REQ_DEPTH + 1);

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_QUERY  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [31:0] key_value;
  } in_req_t;

  typedef struct packed {
    logic [31:0] max_xor;
    status_e     status;
  } out_rsp_t;

  typedef struct packed {
    req_type_e           op;
    logic [KEY_BITS-1:0] key;
  } cmd_t;

  // index [1] is the child for key bit 1, [0] for key bit 0; 0 means no child
  typedef logic [1:0][IDX_W-1:0] link_pair_t;

endpackage

>>> rtl/core/btmx_front.sv
// ---------------------------------------------------------------------------
// btmx_front: request intake
// Accepts requests, classifies them into walk commands and holds them in a
// short queue so intake keeps going while the walker is busy.
// ---------------------------------------------------------------------------
module btmx_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  btmx_pkg::in_req_t req_i,
  output logic              cmd_valid_o,
  output btmx_pkg::cmd_t    cmd_o,
  input  logic              cmd_pop_i
);

  btmx_pkg::cmd_t                    slot_q [btmx_pkg::REQ_DEPTH];
  logic [btmx_pkg::REQ_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [btmx_pkg::REQ_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [btmx_pkg::REQ_CNT_W-1:0]    cnt_q, cnt_d;
  logic                              wr_en, rd_en;
  btmx_pkg::cmd_t                    cmd_new;

  assign full_o      = (cnt_q == btmx_pkg::REQ_CNT_W'(btmx_pkg::REQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cmd_new.op  = req_i.req_type;
    cmd_new.key = req_i.key_value[btmx_pkg::KEY_BITS-1:0];
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + btmx_pkg::REQ_PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = rd_ptr_q + btmx_pkg::REQ_PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + btmx_pkg::REQ_CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - btmx_pkg::REQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

>>> rtl/core/btmx_walk.sv
// ---------------------------------------------------------------------------
// btmx_walk: trie walker
// Owns the node table. Walks one trie level per cycle for inserts and
// queries, checks capacity, allocates new nodes and holds the result.
// ---------------------------------------------------------------------------
module btmx_walk (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  btmx_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output btmx_pkg::out_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_CHECK = 4'b0100,
    S_ALLOC = 4'b1000
  } state_e;

  localparam int SUM_W = btmx_pkg::NU_W + 1;

  state_e                           state_q, state_d;
  btmx_pkg::req_type_e              op_q, op_d;
  logic [btmx_pkg::KEY_BITS-1:0]    key_q, key_d;
  logic [btmx_pkg::LVL_W-1:0]       lvl_q, lvl_d;
  logic [btmx_pkg::IDX_W-1:0]       node_q, node_d;
  logic                             at_root_q, at_root_d;
  logic [btmx_pkg::KEY_BITS-1:0]    best_q, best_d;
  btmx_pkg::link_pair_t             pair_q, pair_d;
  logic [btmx_pkg::LVL_W:0]         needed_q, needed_d;
  logic [btmx_pkg::NU_W-1:0]        nu_q, nu_d;
  logic [btmx_pkg::IDX_W-1:0]       fresh_q, fresh_d;
  logic                             keys_stored_q, keys_stored_d;
  btmx_pkg::link_pair_t             root_q, root_d;
  logic                             res_valid_q, res_valid_d;
  btmx_pkg::out_rsp_t               res_q, res_d;

  btmx_pkg::link_pair_t             mem [btmx_pkg::NODE_CAPACITY];
  btmx_pkg::link_pair_t             rdata_q;
  logic [btmx_pkg::IDX_W-1:0]       mem_raddr;
  logic                             mem_we;
  logic [btmx_pkg::IDX_W-1:0]       mem_waddr;
  btmx_pkg::link_pair_t             mem_wdata;

  btmx_pkg::link_pair_t             cur_pair;
  btmx_pkg::link_pair_t             new_pair;
  logic                             bit_c;
  logic [btmx_pkg::IDX_W-1:0]       opp_link, same_link, nxt_link;
  logic                             go;
  logic [btmx_pkg::LVL_W-1:0]       lvl_m1;
  logic [btmx_pkg::IDX_W-1:0]       nu_idx;
  logic [SUM_W-1:0]                 need_total;

  assign empty_o = !res_valid_q;
  assign rsp_o   = res_q;

  // the root lives in flops so reset can clear it; every other entry is
  // written when allocated, before anything reads it
  assign cur_pair   = at_root_q ? root_q : rdata_q;
  assign bit_c      = key_q[lvl_q];
  assign opp_link   = cur_pair[~bit_c];
  assign same_link  = cur_pair[bit_c];
  assign lvl_m1     = lvl_q - btmx_pkg::LVL_W'(1);
  assign nu_idx     = nu_q[btmx_pkg::IDX_W-1:0];
  assign need_total = SUM_W'(nu_q) + SUM_W'(needed_q);

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    key_d         = key_q;
    lvl_d         = lvl_q;
    node_d        = node_q;
    at_root_d     = at_root_q;
    best_d        = best_q;
    pair_d        = pair_q;
    needed_d      = needed_q;
    nu_d          = nu_q;
    fresh_d       = fresh_q;
    keys_stored_d = keys_stored_q;
    root_d        = root_q;
    res_valid_d   = res_valid_q;
    res_d         = res_q;
    cmd_pop_o     = 1'b0;
    mem_raddr     = node_q;
    mem_we        = 1'b0;
    mem_waddr     = fresh_q;
    mem_wdata     = '0;
    new_pair      = pair_q;
    nxt_link      = '0;
    go            = 1'b0;

    if (pop_i && res_valid_q) begin
      res_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !res_valid_q) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          key_d     = cmd_i.key;
          lvl_d     = btmx_pkg::LVL_W'(btmx_pkg::KEY_BITS - 1);
          node_d    = '0;
          at_root_d = 1'b1;
          best_d    = '0;
          if (cmd_i.op == btmx_pkg::REQ_QUERY && !keys_stored_q) begin
            res_d.max_xor = '0;
            res_d.status  = btmx_pkg::ST_EMPTY;
            res_valid_d   = 1'b1;
          end else begin
            state_d = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (op_q == btmx_pkg::REQ_QUERY) begin
          // prefer the opposite child: it sets this bit of the answer
          if (opp_link != '0) begin
            best_d[lvl_q] = 1'b1;
            nxt_link      = opp_link;
            go            = 1'b1;
          end else if (same_link != '0) begin
            nxt_link = same_link;
            go       = 1'b1;
          end
          if (!go || lvl_q == '0) begin
            res_d.max_xor = 32'(best_d);
            res_d.status  = btmx_pkg::ST_OK;
            res_valid_d   = 1'b1;
            state_d       = S_IDLE;
          end else begin
            mem_raddr = nxt_link;
            node_d    = nxt_link;
            at_root_d = 1'b0;
            lvl_d     = lvl_m1;
          end
        end else begin
          if (same_link == '0) begin
            pair_d   = cur_pair;
            needed_d = {1'b0, lvl_q} + (btmx_pkg::LVL_W + 1)'(1);
            state_d  = S_CHECK;
          end else if (lvl_q == '0) begin
            // key already stored
            keys_stored_d = 1'b1;
            res_d.max_xor = '0;
            res_d.status  = btmx_pkg::ST_OK;
            res_valid_d   = 1'b1;
            state_d       = S_IDLE;
          end else begin
            mem_raddr = same_link;
            node_d    = same_link;
            at_root_d = 1'b0;
            lvl_d     = lvl_m1;
          end
        end
      end

      S_CHECK: begin
        if (need_total > SUM_W'(btmx_pkg::NODE_CAPACITY)) begin
          res_d.max_xor = '0;
          res_d.status  = btmx_pkg::ST_FULL;
          res_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end else begin
          new_pair[bit_c] = nu_idx;
          if (at_root_q) begin
            root_d = new_pair;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = node_q;
            mem_wdata = new_pair;
          end
          fresh_d = nu_idx;
          nu_d    = nu_q + btmx_pkg::NU_W'(1);
          state_d = S_ALLOC;
        end
      end

      S_ALLOC: begin
        mem_we    = 1'b1;
        mem_waddr = fresh_q;
        if (lvl_q == '0) begin
          // leaf: no children
          mem_wdata     = '0;
          keys_stored_d = 1'b1;
          res_d.max_xor = '0;
          res_d.status  = btmx_pkg::ST_OK;
          res_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end else begin
          mem_wdata            = '0;
          mem_wdata[key_q[lvl_m1]] = nu_idx;
          fresh_d              = nu_idx;
          nu_d                 = nu_q + btmx_pkg::NU_W'(1);
          lvl_d                = lvl_m1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      nu_q          <= btmx_pkg::NU_W'(1);
      keys_stored_q <= 1'b0;
      root_q        <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      nu_q          <= nu_d;
      keys_stored_q <= keys_stored_d;
      root_q        <= root_d;
      res_valid_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    lvl_q     <= lvl_d;
    node_q    <= node_d;
    at_root_q <= at_root_d;
    best_q    <= best_d;
    pair_q    <= pair_d;
    needed_q  <= needed_d;
    fresh_q   <= fresh_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  a_nodes_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nu_q <= btmx_pkg::NU_W'(btmx_pkg::NODE_CAPACITY))
    else $error("node count beyond table capacity");

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !res_valid_q)
    else $error("walk in progress while a result is pending");

  a_keys_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keys_stored_q |=> keys_stored_q)
    else $error("stored-key flag dropped");

  a_alloc_insert_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK || state_q == S_ALLOC) |-> op_q == btmx_pkg::REQ_INSERT)
    else $error("allocation during a query");

endmodule

>>> rtl/core/binary_trie_max_xor_unit.sv
// ---------------------------------------------------------------------------
// binary_trie_max_xor_unit: binary trie with maximum-XOR queries
// Insert keys into a fixed node table; query the largest key XOR stored key.
// ---------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   push / full          req_i  (req_type, key_value)
//  result    pop / empty          rsp_o  (max_xor, status)
//
//  Flow: a start state, then a walk of one trie level at a time (up to 32);
//  an insert adds a capacity check and one allocation write per new node.
//  The rate is set by the node memory: one read or write per level per cycle.
//  Reset clears the root links and counters; no clearing pass is needed.
//  A two-entry request queue keeps intake open while the walker or the
//  result register is stalled.
// ---------------------------------------------------------------------------
module binary_trie_max_xor_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  btmx_pkg::in_req_t  req_i,
  output logic               empty,
  input  logic               pop,
  output btmx_pkg::out_rsp_t rsp_o
);

  logic           cmd_valid;
  logic           cmd_pop;
  btmx_pkg::cmd_t cmd;

  btmx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  btmx_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .rsp_o       (rsp_o)
  );

endmodule
